// ===== sv/fjb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fjb_pkg: shared types and constants of the frame jitter buffer
// Status codes, controller states, and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package fjb_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int CAP_FACTOR = 4;
  localparam int SEQ_W      = 32;
  localparam int TAG_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int HELD_W     = 7;
  localparam int JF_W       = 5;
  localparam int JF_MIN     = 2;

  localparam logic [JF_W-1:0] JF_RESET = 5'd12;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_JITTER = '0;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_STORED   = 3'd0;
  localparam status_t ST_DUP      = 3'd1;
  localparam status_t ST_LATE     = 3'd2;
  localparam status_t ST_PLAY     = 3'd3;
  localparam status_t ST_LOST     = 3'd4;
  localparam status_t ST_UNDERRUN = 3'd5;
  localparam status_t ST_WAIT     = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_ARR,
    S_EVCHK,
    S_EVSCAN,
    S_EVICT,
    S_TICK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic check;
    logic scan_clr;
    logic scan_run;
    logic arr_decide;
    logic evict_do;
    logic tick_decide;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic req_tick;
    logic late;
    logic wait_tick;
    logic scan_last;
    logic over_cap;
  } stat_t;

endpackage
`default_nettype wire

// ===== sv/fjb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fjb_ctrl: sequencer of the frame jitter buffer
// Steps one item through check, table scans, decision and eviction, and
// owns the input stall and the output valid.
// ----------------------------------------------------------------------------
module fjb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  fjb_pkg::stat_t st,
  output fjb_pkg::cmd_t  cmd
);
  import fjb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (st.req_tick ? st.wait_tick : st.late) state_next = S_DONE;
        else state_next = S_SCAN;
      end
      S_SCAN: begin
        if (st.scan_last) state_next = st.req_tick ? S_TICK : S_ARR;
      end
      S_ARR: begin
        state_next = S_EVCHK;
      end
      S_EVCHK: begin
        state_next = st.over_cap ? S_EVSCAN : S_DONE;
      end
      S_EVSCAN: begin
        if (st.scan_last) state_next = S_EVICT;
      end
      S_EVICT: begin
        state_next = S_EVCHK;
      end
      S_TICK: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE:   cmd.start = in_valid;
      S_CHECK: begin
        cmd.check    = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      S_SCAN:   cmd.scan_run = 1'b1;
      S_ARR:    cmd.arr_decide = 1'b1;
      S_EVCHK:  cmd.scan_clr = 1'b1;
      S_EVSCAN: cmd.scan_run = 1'b1;
      S_EVICT:  cmd.evict_do = 1'b1;
      S_TICK:   cmd.tick_decide = 1'b1;
      S_DONE:   cmd.load_out = !out_valid || !out_stall;
      default:  cmd = '0;
    endcase
  end

  // hold a result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fjb_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fjb_dp: datapath of the frame jitter buffer
// Entry table in memory, valid bits, one-entry-a-cycle scan unit, playout
// state and the result register.
// ----------------------------------------------------------------------------
module fjb_dp #(
  parameter int BUFFER_DEPTH = fjb_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fjb_pkg::cmd_t                cmd,
  output fjb_pkg::stat_t               st,
  input  logic [fjb_pkg::JF_W-1:0]     jitter_frames,
  input  logic                         req_type,
  input  logic [fjb_pkg::SEQ_W-1:0]    seq,
  input  logic [fjb_pkg::TAG_W-1:0]    frame_tag,
  output logic [fjb_pkg::STATUS_W-1:0] status,
  output logic [fjb_pkg::TAG_W-1:0]    play_tag,
  output logic [fjb_pkg::SEQ_W-1:0]    play_seq,
  output logic                         evicted,
  output logic [fjb_pkg::HELD_W-1:0]   held_count
);
  import fjb_pkg::*;

  localparam int AW   = $clog2(BUFFER_DEPTH);
  localparam int CW   = $clog2(BUFFER_DEPTH + 1);
  localparam int JMAX = BUFFER_DEPTH / CAP_FACTOR;
  localparam int JD_W = $clog2(JMAX + 1);
  localparam int XW   = JD_W + JF_W;
  localparam int KW   = CW + JD_W + $clog2(CAP_FACTOR) + 1;

  logic [SEQ_W-1:0] mem_seq [BUFFER_DEPTH];
  logic [TAG_W-1:0] mem_tag [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] valid;

  // item
  logic             req;
  logic [SEQ_W-1:0] s;
  logic [TAG_W-1:0] tag;

  // playout state
  logic [CW-1:0]    held;
  logic [SEQ_W-1:0] nps;
  logic             have_next;
  logic             pb;

  // scan unit
  logic [AW:0]      cnt;
  logic             issue;
  logic             p_vld;
  logic [AW-1:0]    p_idx;
  logic [SEQ_W-1:0] rd_seq;
  logic [TAG_W-1:0] rd_tag;
  logic [SEQ_W-1:0] key;
  logic             v;
  logic             hit_m, hit_f, hit_l;
  logic             m_found, f_found, l_found;
  logic [AW-1:0]    m_idx, f_idx, l_idx;
  logic [TAG_W-1:0] m_tag;
  logic [SEQ_W-1:0] l_seq;

  // work result
  status_t          w_status;
  logic [TAG_W-1:0] w_tag;
  logic [SEQ_W-1:0] w_seq;
  logic             w_ev;

  // depth and capacity
  logic [XW-1:0]    jf_x, jd_x;
  logic [JD_W-1:0]  jd;
  logic [KW-1:0]    jd_k, cap_k, held_k;
  logic             pb_eff;
  logic [SEQ_W-1:0] nps_eff;

  // eviction push and table write
  logic             new_lowest;
  logic [SEQ_W-1:0] push_val, push_inc, push_nps;
  logic             we_seq, we_tag;
  logic [AW-1:0]    wa;
  logic [CW+HELD_W-1:0] held_h;

  // clamp jitter depth to JF_MIN .. BUFFER_DEPTH/CAP_FACTOR
  assign jf_x   = XW'(jitter_frames);
  assign jd_x   = (jf_x < XW'(JF_MIN)) ? XW'(JF_MIN) :
                  (jf_x > XW'(JMAX))   ? XW'(JMAX)   : jf_x;
  assign jd     = jd_x[JD_W-1:0];
  assign jd_k   = KW'(jd);
  assign cap_k  = jd_k * KW'(CAP_FACTOR);
  assign held_k = KW'(held);

  assign nps_eff = have_next ? nps : s;
  assign pb_eff  = pb && !(held_k >= jd_k);
  assign key     = req ? nps : s;

  assign issue = cmd.scan_run && (cnt < (AW+1)'(BUFFER_DEPTH));
  assign v     = valid[p_idx];
  assign hit_m = cmd.scan_run && p_vld && v && (rd_seq == key) && !m_found;
  assign hit_f = cmd.scan_run && p_vld && !v && !f_found;
  assign hit_l = cmd.scan_run && p_vld && v && (!l_found || (rd_seq < l_seq));

  always_comb begin
    st.req_tick  = req;
    st.late      = !req && (s < nps_eff);
    st.wait_tick = req && (pb_eff || !have_next);
    st.scan_last = (cnt == (AW+1)'(BUFFER_DEPTH)) && !p_vld;
    st.over_cap  = held_k > cap_k;
  end

  // full table: the new frame is the lowest when it sits below every entry
  assign new_lowest = !l_found || (s < l_seq);
  assign push_val   = cmd.evict_do ? l_seq : (new_lowest ? s : l_seq);
  assign push_inc   = push_val + SEQ_W'(1);
  assign push_nps   = (push_inc > nps) ? push_inc : nps;

  always_comb begin
    we_seq = 1'b0;
    we_tag = 1'b0;
    wa     = m_idx;
    if (cmd.arr_decide) begin
      if (m_found) begin
        we_tag = 1'b1;
      end else if (f_found) begin
        we_seq = 1'b1;
        we_tag = 1'b1;
        wa     = f_idx;
      end else if (!new_lowest) begin
        we_seq = 1'b1;
        we_tag = 1'b1;
        wa     = l_idx;
      end
    end
  end

  // entry table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we_seq) mem_seq[wa] <= s;
    if (we_tag) mem_tag[wa] <= tag;
    if (issue) begin
      rd_seq <= mem_seq[cnt[AW-1:0]];
      rd_tag <= mem_tag[cnt[AW-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      held      <= '0;
      nps       <= '0;
      have_next <= 1'b0;
      pb        <= 1'b1;
      cnt       <= '0;
      p_vld     <= 1'b0;
      m_found   <= 1'b0;
      f_found   <= 1'b0;
      l_found   <= 1'b0;
    end else begin
      if (cmd.check) begin
        if (!req && !have_next) begin
          have_next <= 1'b1;
          nps       <= s;
        end
        if (req && pb && (held_k >= jd_k)) pb <= 1'b0;
      end
      if (cmd.scan_clr) begin
        cnt     <= '0;
        p_vld   <= 1'b0;
        m_found <= 1'b0;
        f_found <= 1'b0;
        l_found <= 1'b0;
      end else if (cmd.scan_run) begin
        p_vld <= issue;
        if (issue) cnt <= cnt + (AW+1)'(1);
        if (hit_m) m_found <= 1'b1;
        if (hit_f) f_found <= 1'b1;
        if (hit_l) l_found <= 1'b1;
      end
      if (cmd.arr_decide && !m_found) begin
        if (f_found) begin
          valid[f_idx] <= 1'b1;
          held         <= held + CW'(1);
        end else begin
          nps <= push_nps;
        end
      end
      if (cmd.evict_do) begin
        if (l_found) begin
          nps          <= push_nps;
          valid[l_idx] <= 1'b0;
          held         <= held - CW'(1);
        end else begin
          held <= '0;
        end
      end
      if (cmd.tick_decide) begin
        if (m_found) begin
          valid[m_idx] <= 1'b0;
          held         <= held - CW'(1);
          nps          <= nps + SEQ_W'(1);
        end else if (held != '0) begin
          nps <= nps + SEQ_W'(1);
        end else begin
          pb <= 1'b1;
        end
      end
    end
  end

  // item capture and scan results
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req <= req_type;
      s   <= seq;
      tag <= frame_tag;
    end
    if (issue) p_idx <= cnt[AW-1:0];
    if (hit_m) begin
      m_idx <= p_idx;
      m_tag <= rd_tag;
    end
    if (hit_f) f_idx <= p_idx;
    if (hit_l) begin
      l_idx <= p_idx;
      l_seq <= rd_seq;
    end
  end

  // work result and output register
  assign held_h = {{HELD_W{1'b0}}, held};

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      w_status <= req ? ST_WAIT : ST_LATE;
      w_tag    <= '0;
      w_seq    <= '0;
      w_ev     <= 1'b0;
    end
    if (cmd.arr_decide) begin
      w_status <= m_found ? ST_DUP : ST_STORED;
      if (!m_found && !f_found) w_ev <= 1'b1;
    end
    if (cmd.evict_do && l_found) w_ev <= 1'b1;
    if (cmd.tick_decide) begin
      w_seq <= nps;
      if (m_found) begin
        w_status <= ST_PLAY;
        w_tag    <= m_tag;
      end else if (held != '0) begin
        w_status <= ST_LOST;
      end else begin
        w_status <= ST_UNDERRUN;
      end
    end
    if (cmd.load_out) begin
      status     <= w_status;
      play_tag   <= w_tag;
      play_seq   <= w_seq;
      evicted    <= w_ev;
      held_count <= held_h[HELD_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== sv/frame_jitter_buffer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frame_jitter_buffer: reordering jitter buffer for sequenced audio frames
// Stores (seq, tag) pairs of arriving frames, drops late ones, evicts the
// oldest above capacity, and answers playout ticks with play, lost, underrun
// or waiting silence.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 beat contents
//  --------  ------------------------  --------------------------------------
//  input     in_valid / in_stall       req_type, seq, frame_tag
//  output    out_valid / out_stall     status, play_tag, play_seq, evicted,
//                                      held_count
//  config    psel/penable/pwrite       jitter_frames at byte address 0
//
//  One input beat at a time. A late arrival or a waiting tick goes from the
//  check straight to its result; any other beat scans the whole entry table
//  once through the single memory read port, and each eviction adds a
//  further scan of the table.
//  The output register holds a finished beat while out_stall is high; the next
//  input beat is taken meanwhile and its result waits behind it.
//  Reset is synchronous: the table reads empty at once (valid bits clear),
//  prebuffering is on and jitter_frames returns to 12.
//
module frame_jitter_buffer #(
  parameter int BUFFER_DEPTH = fjb_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         req_type,
  input  logic [fjb_pkg::SEQ_W-1:0]    seq,
  input  logic [fjb_pkg::TAG_W-1:0]    frame_tag,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fjb_pkg::STATUS_W-1:0] status,
  output logic [fjb_pkg::TAG_W-1:0]    play_tag,
  output logic [fjb_pkg::SEQ_W-1:0]    play_seq,
  output logic                         evicted,
  output logic [fjb_pkg::HELD_W-1:0]   held_count,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fjb_pkg::APB_AW-1:0]   paddr,
  input  logic [fjb_pkg::APB_DW-1:0]   pwdata,
  output logic [fjb_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import fjb_pkg::*;

  logic [JF_W-1:0] jitter_frames;
  logic            cfg_wr;
  logic            sel_jitter;
  cmd_t            cmd;
  stat_t           st;

  // Register file: a single register, written on the access phase.
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign sel_jitter = (paddr[APB_AW-1:2] == REG_JITTER);
  assign prdata     = sel_jitter ? APB_DW'(jitter_frames) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      jitter_frames <= JF_RESET;
    end else if (cfg_wr && sel_jitter) begin
      jitter_frames <= pwdata[JF_W-1:0];
    end
  end

  // Sequencer: walks each beat through check, scan, decide and evict.
  fjb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath: entry table, scan unit, playout state and result register.
  fjb_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .jitter_frames (jitter_frames),
    .req_type      (req_type),
    .seq           (seq),
    .frame_tag     (frame_tag),
    .status        (status),
    .play_tag      (play_tag),
    .play_seq      (play_seq),
    .evicted       (evicted),
    .held_count    (held_count)
  );

  // One beat in flight: after a beat is taken, the input stalls.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a beat is still in work");

  // Ticks never report an eviction.
  a_tick_no_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_PLAY || status == ST_LOST ||
                   status == ST_UNDERRUN || status == ST_WAIT)) |-> !evicted)
    else $error("eviction flagged on a playout tick");

  // A tag leaves the block only with a play result.
  a_tag_on_play: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_PLAY) |-> (play_tag == '0))
    else $error("play tag driven without a play result");

  // Underrun means the table is empty.
  a_underrun_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_UNDERRUN) |-> (held_count == '0))
    else $error("underrun reported with entries held");

endmodule
`default_nettype wire

// ===== tb/sv/fjb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjb_checker: result predictor and scoreboard for the frame jitter buffer
// Watches the input, output and register channels, keeps its own copy of the
// entry table and playout state, and compares every output beat in order.
// ----------------------------------------------------------------------------
module fjb_checker #(
  parameter int DEPTH = fjb_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         req_type,
  input  logic [fjb_pkg::SEQ_W-1:0]    seq,
  input  logic [fjb_pkg::TAG_W-1:0]    frame_tag,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [fjb_pkg::STATUS_W-1:0] status,
  input  logic [fjb_pkg::TAG_W-1:0]    play_tag,
  input  logic [fjb_pkg::SEQ_W-1:0]    play_seq,
  input  logic                         evicted,
  input  logic [fjb_pkg::HELD_W-1:0]   held_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fjb_pkg::APB_AW-1:0]   paddr,
  input  logic [fjb_pkg::APB_DW-1:0]   pwdata,
  input  logic [fjb_pkg::APB_DW-1:0]   prdata,
  input  logic                         pready,
  output int                           mismatches,
  output int                           pending
);
  import fjb_pkg::*;

  typedef struct {
    status_t           st;
    logic [TAG_W-1:0]  tag;
    logic [SEQ_W-1:0]  pseq;
    logic              ev;
    logic [HELD_W-1:0] held;
  } frame_result_t;

  frame_result_t expected_results[$];
  frame_result_t got, want;

  logic [SEQ_W-1:0] slot_seq [DEPTH];
  logic [TAG_W-1:0] slot_tag [DEPTH];
  logic             slot_used [DEPTH];
  int               held;
  logic [SEQ_W-1:0] next_seq;
  logic             seq_known;
  logic             prebuffering;
  logic [JF_W-1:0]  jitter_reg;
  int               err_count;

  initial begin
    mismatches = 0;
    pending    = 0;
    err_count  = 0;
  end

  function automatic void flag(input string what);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $realtime, what);
  endfunction

  function automatic int slot_holding(input logic [SEQ_W-1:0] s);
    for (int i = 0; i < DEPTH; i++)
      if (slot_used[i] && slot_seq[i] == s) return i;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < DEPTH; i++)
      if (!slot_used[i]) return i;
    return -1;
  endfunction

  function automatic int lowest_slot();
    int best;
    best = -1;
    for (int i = 0; i < DEPTH; i++)
      if (slot_used[i] && (best < 0 || slot_seq[i] < slot_seq[best])) best = i;
    return best;
  endfunction

  // move the playout point past s; s + 1 wraps, so the top value moves nothing
  function automatic void advance_past(input logic [SEQ_W-1:0] s);
    logic [SEQ_W-1:0] nxt;
    nxt = s + 1'b1;
    if (nxt > next_seq) next_seq = nxt;
  endfunction

  function automatic frame_result_t predict_beat(input logic rt,
                                                 input logic [SEQ_W-1:0] s,
                                                 input logic [TAG_W-1:0] tg);
    frame_result_t r;
    int jd, cap, k, lo;
    r.st   = ST_STORED;
    r.tag  = '0;
    r.pseq = '0;
    r.ev   = 1'b0;
    jd = int'(jitter_reg);
    if (jd < JF_MIN) jd = JF_MIN;
    if (jd > DEPTH / CAP_FACTOR) jd = DEPTH / CAP_FACTOR;
    cap = CAP_FACTOR * jd;
    if (!rt) begin
      if (!seq_known) begin
        seq_known = 1'b1;
        next_seq  = s;
      end
      if (s < next_seq) begin
        r.st = ST_LATE;
      end else begin
        k = slot_holding(s);
        if (k >= 0) begin
          slot_tag[k] = tg;
          r.st = ST_DUP;
        end else begin
          k = free_slot();
          if (k >= 0) begin
            slot_seq[k]  = s;
            slot_tag[k]  = tg;
            slot_used[k] = 1'b1;
            held++;
          end else begin
            // table full: the lowest of the table and the new frame goes
            lo = lowest_slot();
            r.ev = 1'b1;
            if (lo < 0 || s < slot_seq[lo]) begin
              advance_past(s);
            end else begin
              advance_past(slot_seq[lo]);
              slot_seq[lo] = s;
              slot_tag[lo] = tg;
            end
          end
        end
        while (held > cap) begin
          lo = lowest_slot();
          if (lo < 0) begin
            held = 0;
            break;
          end
          advance_past(slot_seq[lo]);
          slot_used[lo] = 1'b0;
          held--;
          r.ev = 1'b1;
        end
      end
    end else begin
      if (prebuffering && held >= jd) prebuffering = 1'b0;
      if (prebuffering || !seq_known) begin
        r.st = ST_WAIT;
      end else begin
        k = slot_holding(next_seq);
        r.pseq = next_seq;
        if (k >= 0) begin
          r.st = ST_PLAY;
          r.tag = slot_tag[k];
          slot_used[k] = 1'b0;
          held--;
          next_seq++;
        end else if (held > 0) begin
          r.st = ST_LOST;
          next_seq++;
        end else begin
          r.st = ST_UNDERRUN;
          prebuffering = 1'b1;
        end
      end
    end
    r.held = HELD_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
      held         = 0;
      next_seq     = '0;
      seq_known    = 1'b0;
      prebuffering = 1'b1;
      jitter_reg   = JF_RESET;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1) begin
        if (pwrite) begin
          if (paddr[APB_AW-1:2] == REG_JITTER) jitter_reg = pwdata[JF_W-1:0];
        end else if (prdata !== APB_DW'(jitter_reg)) begin
          flag($sformatf("register read mismatch: expected %h got %h",
                         APB_DW'(jitter_reg), prdata));
        end
      end

      // retire the oldest expectation before queuing a new one
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got.st   = status;
        got.tag  = play_tag;
        got.pseq = play_seq;
        got.ev   = evicted;
        got.held = held_count;
        if (expected_results.size() == 0) begin
          flag($sformatf("unexpected result beat: status %0d tag %h seq %h",
                         got.st, got.tag, got.pseq));
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got.st !== want.st || got.tag !== want.tag || got.pseq !== want.pseq ||
              got.ev !== want.ev || got.held !== want.held)
            flag($sformatf({"result mismatch: expected status %0d tag %h seq %h ev %0d ",
                            "held %0d, got status %0d tag %h seq %h ev %0d held %0d"},
                           want.st, want.tag, want.pseq, want.ev, want.held,
                           got.st, got.tag, got.pseq, got.ev, got.held));
        end
      end

      if (in_valid === 1'b1 && in_stall === 1'b0)
        expected_results.insert(expected_results.size(),
                                predict_beat(req_type, seq, frame_tag));

      pending <= expected_results.size();
    end
    mismatches <= err_count;
  end

endmodule

// ===== tb/sv/tb_frame_jitter_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_jitter_buffer: self-checking bench for the frame jitter buffer
// A short directed run walks through every status, then phases of reordered
// frame streams with lost, repeated and late frames are played out under
// changing jitter depths, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_frame_jitter_buffer;
  import fjb_pkg::*;

  localparam int NUM_PHASES  = 14;
  localparam int PHASE_BEATS = 75;
  // watchdog limit on the length of the whole run
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 2 * DEPTH_DEF + 16;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                req_type;
  logic [SEQ_W-1:0]    seq;
  logic [TAG_W-1:0]    frame_tag;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] status;
  logic [TAG_W-1:0]    play_tag;
  logic [SEQ_W-1:0]    play_seq;
  logic                evicted;
  logic [HELD_W-1:0]   held_count;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int          mismatches;
  int          pending;
  int unsigned cycle_count = 0;

  // jitter depth per phase: clamped extremes at both ends, a deep phase that
  // fills the whole table, then a shallow one right after to force a mass
  // eviction when the capacity drops
  int jitter_plan [NUM_PHASES] = '{12, 31, 2, 16, 31, 1, 5, 8, 3, 20, 0, 7, 16, 9};
  // share of arrivals among beats, in percent; below 50 drains toward underrun
  int arrival_pct [NUM_PHASES] = '{55, 60, 50, 95, 90, 50, 38, 55, 45, 60, 50, 65, 50, 55};

  // sender-side stream state
  logic [SEQ_W-1:0] stream_next;
  logic [SEQ_W-1:0] last_sent;
  logic [SEQ_W-1:0] phase_base;
  logic [SEQ_W-1:0] reorder_pool[$];
  int               burst_left = 0;

  frame_jitter_buffer DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .seq        (seq),
    .frame_tag  (frame_tag),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .play_tag   (play_tag),
    .play_seq   (play_seq),
    .evicted    (evicted),
    .held_count (held_count),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  fjb_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .seq        (seq),
    .frame_tag  (frame_tag),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .play_tag   (play_tag),
    .play_seq   (play_seq),
    .evicted    (evicted),
    .held_count (held_count),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: end the run if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: cycle through open stretches, random stalls, long holds and a
  // toggling pattern, so stalls land on every stage of a beat's processing.
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0: begin
          n = $urandom_range(50, 400);
          @(negedge clk);
          out_stall = 1'b0;
          repeat (n) @(negedge clk);
        end
        1: begin
          n = $urandom_range(50, 300);
          repeat (n) begin
            @(negedge clk);
            out_stall = ($urandom_range(0, 99) < 30);
          end
        end
        2: begin
          n = $urandom_range(5, 29);
          @(negedge clk);
          out_stall = 1'b1;
          repeat (n) @(negedge clk);
          out_stall = 1'b0;
        end
        default: begin
          n = $urandom_range(10, 60);
          repeat (n) begin
            @(negedge clk);
            out_stall = ~out_stall;
          end
        end
      endcase
    end
  end

  // Drive one beat. Beats go out in bursts; between bursts drop valid for a
  // random gap, or none at all. Hold the payload until the beat is taken.
  task automatic send_beat(input logic rt, input logic [SEQ_W-1:0] s,
                           input logic [TAG_W-1:0] tg);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid  = 1'b1;
    req_type  = rt;
    seq       = s;
    frame_tag = tg;
    do @(posedge clk); while (in_stall !== 1'b0);
    burst_left--;
  endtask

  task automatic arrive(input logic [SEQ_W-1:0] s, input logic [TAG_W-1:0] tg);
    send_beat(1'b0, s, tg);
  endtask

  // ticks carry random seq and tag, which the block must ignore
  task automatic tick();
    send_beat(1'b1, $urandom, TAG_W'($urandom));
  endtask

  // Register access: setup phase, then access phase until pready. Unused data bits
  // of a write carry random values.
  task automatic reg_access(input logic wr, input logic [JF_W-1:0] jf);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {REG_JITTER, 2'b00};
    pwdata  = $urandom;
    pwdata[JF_W-1:0] = jf;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Hold off until every result has come back; every beat yields one result,
  // so the checker's pending count shows when the block has gone idle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    int r;
    int pick;
    int pool_max;
    logic [SEQ_W-1:0] s;

    rst       = 1'b1;
    in_valid  = 1'b0;
    req_type  = 1'b0;
    seq       = '0;
    frame_tag = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // read back the reset depth, then go to the clamped minimum
    reg_access(1'b0, '0);
    reg_access(1'b1, 5'd0);
    reg_access(1'b0, '0);

    // ---- directed: every status, extremes of tag, late seq zero ----
    tick();                        // nothing arrived yet: waiting silence
    arrive(32'd100, 16'hFFFF);     // first arrival sets the playout point
    arrive(32'd100, 16'h0000);     // same seq again: overwrite the tag
    arrive(32'd99, 16'h1234);      // below the playout point: late
    tick();                        // one held, depth two: still prebuffering
    arrive(32'd102, 16'h5A5A);
    tick();                        // play 100
    tick();                        // 101 never came: lost
    tick();                        // play 102
    tick();                        // empty: underrun, back to prebuffering
    for (int i = 103; i <= 111; i++)
      arrive(i, TAG_W'($urandom)); // ninth one overflows capacity 8: evict
    arrive(32'd0, 16'hFFFF);
    tick();

    stream_next = 32'd112;
    last_sent   = 32'd111;

    // ---- random phases of reordered streams ----
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      reg_access(1'b1, JF_W'(jitter_plan[p]));
      reg_access(1'b0, '0);

      // Move the stream forward. Large jumps strand the playout point until
      // the backlog overflows capacity and evictions pull it forward. The
      // last phase runs across the top of the sequence space and wraps.
      if (p == NUM_PHASES - 1) begin
        if (stream_next < 32'hFFFF_FFE0) stream_next = 32'hFFFF_FFE0;
      end else begin
        case ($urandom_range(0, 3))
          0: ;
          1: stream_next += $urandom_range(1, 40);
          2: stream_next += $urandom_range(100, 100000);
          default: begin
            if (stream_next < 32'hE000_0000)
              stream_next += $urandom_range(0, (32'hF000_0000 - stream_next) / 3);
          end
        endcase
      end
      phase_base = stream_next;
      pool_max   = $urandom_range(1, 4);
      reorder_pool.delete();

      repeat (PHASE_BEATS) begin
        if ($urandom_range(0, 99) < arrival_pct[p]) begin
          r = $urandom_range(0, 99);
          if (r < 6) begin
            // stale frame: far below the stream, or a little behind it
            if ($urandom_range(0, 1) && phase_base >= 1000 && stream_next >= phase_base)
              s = $urandom_range(0, phase_base - 1000);
            else
              s = last_sent - ((last_sent > 64) ? $urandom_range(20, 60) : 0);
          end else if (r < 12) begin
            // resend of a recent frame: duplicate, or late once played
            s = last_sent - ((last_sent > 2) ? $urandom_range(0, 2) : 0);
          end else begin
            // in-order stream through a small shuffle pool, with gaps
            while (reorder_pool.size() < pool_max) begin
              if ($urandom_range(0, 99) < 8) stream_next++;
              reorder_pool.insert(reorder_pool.size(), stream_next);
              stream_next++;
            end
            pick = $urandom_range(0, reorder_pool.size() - 1);
            s = reorder_pool[pick];
            reorder_pool.delete(pick);
            last_sent = s;
          end
          arrive(s, TAG_W'($urandom));
        end else begin
          tick();
        end
      end
    end

    // drain: let every result come back, then watch for stray beats
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fjb_pkg.sv
sv/fjb_ctrl.sv
sv/fjb_dp.sv
sv/frame_jitter_buffer.sv
tb/sv/fjb_checker.sv
tb/sv/tb_frame_jitter_buffer.sv
